// ===== rtl/sibd_pkg.sv =====
// Shared types and constants for the shift-in button scanner with debounce.
// No dependencies; the scanner, the button bank and the result interface import this package.
`timescale 1ns / 1ps
`default_nettype none

package sibd_pkg;

    localparam int unsigned BUTTON_COUNT = 16;
    localparam int unsigned CURSOR_W     = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int unsigned INDEX_W      = 4;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned COUNTER_W    = 17;

    localparam logic [CFG_W-1:0]     THRESHOLD_RESET = CFG_W'(50000);
    localparam logic [CFG_W-1:0]     STEP_RESET      = CFG_W'(2000);
    localparam logic [COUNTER_W-1:0] COUNTER_MAX     = {COUNTER_W{1'b1}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_QUIET_THRESHOLD = 1'b0,
        CFG_COUNT_STEP      = 1'b1
    } t_cfg_idx;

    // scan phases, one-hot
    typedef enum logic [3:0] {
        ST_LOAD_LO = 4'b0001,
        ST_LOAD_HI = 4'b0010,
        ST_SAMPLE  = 4'b0100,
        ST_CLK_HI  = 4'b1000
    } t_state;

    typedef struct packed {
        logic                en;
        logic [CURSOR_W-1:0] cursor;
        logic                data;
    } t_bank_req;

    typedef struct packed {
        logic changed;
        logic level;
    } t_bank_rsp;

endpackage

`default_nettype wire

// ===== rtl/sibd_in_if.sv =====
// Request channel carrying one serial data sample per scan tick.
// Depends on nothing; valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface sibd_in_if;
    logic valid;
    logic ready;
    logic serial_data;

    modport source (output valid, output serial_data, input ready);
    modport sink   (input valid, input serial_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sibd_out_if.sv =====
// Result channel: line levels and the debounced change event of one tick.
// Depends on sibd_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface sibd_out_if;
    import sibd_pkg::*;

    logic               valid;
    logic               ready;
    logic               load_line;
    logic               clock_line;
    logic               change_valid;
    logic [INDEX_W-1:0] button_index;
    logic               button_level;

    modport source (output valid, output load_line, output clock_line, output change_valid,
                    output button_index, output button_level, input ready);
    modport sink   (input valid, input load_line, input clock_line, input change_valid,
                    input button_index, input button_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/shift_in_button_scan_debounce.sv =====
// Shift-in button scanner with per-button debounce.
// A result is registered on the clock edge that accepts its request.
// One request per cycle unless a pending result stalls; the result register frees as it is taken.
// Every tick is one phase step; a sample-phase tick touches one button counter, in a single pass.
// Reset (synchronous, active low) sets all state but the result payload registers to defaults.
// Depends on sibd_pkg, sibd_in_if, sibd_out_if, sibd_button_bank.
`timescale 1ns / 1ps
`default_nettype none

module shift_in_button_scan_debounce (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sibd_in_if.sink                            i_in,
    sibd_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire sibd_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [sibd_pkg::CFG_W-1:0]    i_cfg_data
);
    import sibd_pkg::*;

    localparam logic [CURSOR_W-1:0] LAST_CURSOR = CURSOR_W'(BUTTON_COUNT - 1);

    t_state              r_state, n_state;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;
    logic                r_load_level, n_load_level;
    logic                r_clock_level, n_clock_level;
    logic [CFG_W-1:0]    r_threshold;
    logic [CFG_W-1:0]    r_step;

    logic                r_out_valid;
    logic                r_out_load;
    logic                r_out_clock;
    logic                r_out_change;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_level;

    logic                accept;
    t_bank_req           bank_req;
    t_bank_rsp           bank_rsp;
    logic [CURSOR_W+INDEX_W-1:0] cursor_ext;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign bank_req.en     = accept && (r_state == ST_SAMPLE);
    assign bank_req.cursor = r_cursor;
    assign bank_req.data   = i_in.serial_data;

    sibd_button_bank u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (bank_req),
        .i_threshold (r_threshold),
        .i_step      (r_step),
        .o_rsp       (bank_rsp)
    );

    assign cursor_ext = {{INDEX_W{1'b0}}, r_cursor};

    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_load_level  = r_load_level;
        n_clock_level = r_clock_level;
        unique case (r_state)
            ST_LOAD_LO: begin
                n_load_level = 1'b0;
                n_state      = ST_LOAD_HI;
            end
            ST_LOAD_HI: begin
                n_load_level = 1'b1;
                n_state      = ST_SAMPLE;
            end
            ST_SAMPLE: begin
                n_clock_level = 1'b0;
                n_state       = ST_CLK_HI;
            end
            ST_CLK_HI: begin
                n_clock_level = 1'b1;
                // wrap to a fresh load after the last button
                if (r_cursor >= LAST_CURSOR) begin
                    n_cursor = '0;
                    n_state  = ST_LOAD_LO;
                end else begin
                    n_cursor = r_cursor + 1'b1;
                    n_state  = ST_SAMPLE;
                end
            end
            default: begin
                n_cursor = '0;
                n_state  = ST_LOAD_LO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD_LO;
            r_cursor      <= '0;
            r_load_level  <= 1'b0;
            r_clock_level <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_state       <= n_state;
                r_cursor      <= n_cursor;
                r_load_level  <= n_load_level;
                r_clock_level <= n_clock_level;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // result payload: loaded on accept, held otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_load   <= n_load_level;
            r_out_clock  <= n_clock_level;
            r_out_change <= bank_rsp.changed && bank_req.en;
            r_out_index  <= (bank_rsp.changed && bank_req.en) ? cursor_ext[INDEX_W-1:0] : '0;
            r_out_level  <= bank_rsp.level && bank_req.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_step      <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUIET_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_COUNT_STEP:      r_step      <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.load_line    = r_out_load;
    assign o_out.clock_line   = r_out_clock;
    assign o_out.change_valid = r_out_change;
    assign o_out.button_index = r_out_index;
    assign o_out.button_level = r_out_level;

    property p_change_in_sample;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_change |-> !r_out_clock && r_out_load;
    endproperty
    a_change_in_sample: assert property (p_change_in_sample)
        else $error("change event outside the sample phase");

    property p_cursor_idle_in_load;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD_LO) || (r_state == ST_LOAD_HI) |-> r_cursor == '0;
    endproperty
    a_cursor_idle_in_load: assert property (p_cursor_idle_in_load)
        else $error("cursor moved during load phases");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !accept;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("request accepted over a pending result");

    property p_wrap_to_load;
        @(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_state == ST_CLK_HI) && (r_cursor == LAST_CURSOR)
            |=> (r_state == ST_LOAD_LO) && (r_cursor == '0);
    endproperty
    a_wrap_to_load: assert property (p_wrap_to_load)
        else $error("scan did not restart after last button");

endmodule

`default_nettype wire

// ===== rtl/sibd_button_bank.sv =====
// Per-button quiet counters and debounced levels; handles one button per request.
// Depends on sibd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sibd_button_bank (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sibd_pkg::t_bank_req         i_req,
    input  wire logic [sibd_pkg::CFG_W-1:0]  i_threshold,
    input  wire logic [sibd_pkg::CFG_W-1:0]  i_step,
    output sibd_pkg::t_bank_rsp              o_rsp
);
    import sibd_pkg::*;

    logic [COUNTER_W-1:0] r_counter [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] r_level;

    logic [CURSOR_W-1:0]  sel;
    logic [COUNTER_W-1:0] cur_count;
    logic                 cur_level;
    logic                 quiet;
    logic [COUNTER_W:0]   sum;
    logic [COUNTER_W-1:0] n_count;
    logic                 n_level;

    // an out-of-range cursor falls back to button 0
    assign sel = (32'(i_req.cursor) < BUTTON_COUNT) ? i_req.cursor : '0;

    assign cur_count = r_counter[sel];
    assign cur_level = r_level[sel];
    assign quiet     = cur_count > COUNTER_W'(i_threshold);
    assign sum       = (COUNTER_W+1)'(cur_count) + (COUNTER_W+1)'(i_step);

    always_comb begin
        n_count = cur_count;
        n_level = cur_level;
        o_rsp   = '0;
        if (quiet) begin
            if (i_req.data != cur_level) begin
                n_level       = i_req.data;
                n_count       = '0;
                o_rsp.changed = 1'b1;
                o_rsp.level   = i_req.data;
            end
        end else begin
            n_count = sum[COUNTER_W] ? COUNTER_MAX : sum[COUNTER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_counter[i] <= '0;
            end
            r_level <= '0;
        end else if (i_req.en) begin
            r_counter[sel] <= n_count;
            r_level[sel]   <= n_level;
        end
    end

    property p_change_needs_quiet;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_req.en && o_rsp.changed |=> r_counter[$past(sel)] == '0;
    endproperty
    a_change_needs_quiet: assert property (p_change_needs_quiet)
        else $error("changed button did not clear its counter");

    property p_level_follows_change;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_req.en && o_rsp.changed |=> r_level[$past(sel)] == $past(i_req.data);
    endproperty
    a_level_follows_change: assert property (p_level_follows_change)
        else $error("stable level not updated on change");

    property p_no_change_when_counting;
        @(posedge i_clk) disable iff (!i_rst_n)
        !quiet |-> !o_rsp.changed;
    endproperty
    a_no_change_when_counting: assert property (p_no_change_when_counting)
        else $error("change reported before quiet time");

endmodule

`default_nettype wire
